[hdl/stb_pkg.sv]
// ----------------------------------------------------------------------------
// stb_pkg
// Types and constants shared by the slot table block allocator.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 24;
    localparam int ADDR_W   = 32;
    localparam int INDEX_W  = 5;

    // command queue between front and engine
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_QUERY,
        CMD_REJECT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind           kind;
        t_status             rej_status;
        logic [SIZE_W-1:0]   req_size;
        logic [ADDR_W-1:0]   block_addr;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   offset;
    } t_slot_word;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_FREE_NEXT
    } t_eng_state;

endpackage

[hdl/stb_req_if.sv]
// ----------------------------------------------------------------------------
// stb_req_if
// Request channel: opcode, requested size and block address.
// ----------------------------------------------------------------------------
interface stb_req_if;
    import stb_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SIZE_W-1:0]   req_size;
    logic [ADDR_W-1:0]   block_addr;

    modport source (output valid, output opcode, output req_size, output block_addr,
                    input ready);
    modport sink   (input valid, input opcode, input req_size, input block_addr,
                    output ready);
endinterface

[hdl/stb_rsp_if.sv]
// ----------------------------------------------------------------------------
// stb_rsp_if
// Response channel: status, block address, slot size and slot index.
// ----------------------------------------------------------------------------
interface stb_rsp_if;
    import stb_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_addr;
    logic [SIZE_W-1:0]   result_size;
    logic [INDEX_W-1:0]  slot_index;

    modport source (output valid, output status, output result_addr, output result_size,
                    output slot_index, input ready);
    modport sink   (input valid, input status, input result_addr, input result_size,
                    input slot_index, output ready);
endinterface

[hdl/stb_cfg_if.sv]
// ----------------------------------------------------------------------------
// stb_cfg_if
// Configuration write channel for the pool base address.
// ----------------------------------------------------------------------------
interface stb_cfg_if;
    import stb_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/slot_table_block_allocator.sv]
// ----------------------------------------------------------------------------
// slot_table_block_allocator
// Allocates, frees and looks up blocks in a pool described by a table of
// SLOTS slots laid out back to back from the pool base. Allocate takes the
// first free slot large enough or claims the first never-used slot; free and
// query find an in-use slot by address. Each request gives one response.
// Requests are taken into a two-entry command queue while the engine works,
// so the request side keeps moving while a response waits. A rejected
// request (zero size, null address, unknown opcode) is answered from the idle
// state without a scan. Allocate, free and query walk the slot table memory at
// one slot per cycle through its single read port; a free of any slot but the
// last also passes through the free-next state to check the slot behind it. Write
// pool_base only while idle.
// ----------------------------------------------------------------------------
module slot_table_block_allocator #(
    parameter int SLOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stb_cfg_if.sink    i_cfg,
    stb_req_if.sink    i_req,
    stb_rsp_if.source  o_rsp
);
    import stb_pkg::*;

    logic [ADDR_W-1:0] r_pool_base;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              fifo_push;
    logic              fifo_full;
    logic              fifo_empty;
    logic              cmd_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
        end else if (i_cfg.valid) begin
            r_pool_base <= i_cfg.data;
        end
    end

    stb_front u_front (
        .i_req  (i_req),
        .i_full (fifo_full),
        .o_push (fifo_push),
        .o_cmd  (push_cmd)
    );

    stb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd),
        .o_empty (fifo_empty)
    );

    stb_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (!fifo_empty),
        .o_cmd_pop   (cmd_pop),
        .i_pool_base (r_pool_base),
        .o_rsp       (o_rsp)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !fifo_empty)
        else $error("command popped from an empty queue");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.result_addr == '0 && o_rsp.result_size == '0 && o_rsp.slot_index == '0))
        else $error("failure response carries nonzero fields");

endmodule

[hdl/stb_front.sv]
// ----------------------------------------------------------------------------
// stb_front
// Accepts requests and classifies them into engine commands; requests that
// need no table scan are turned into reject commands here.
// ----------------------------------------------------------------------------
module stb_front (
    stb_req_if.sink        i_req,
    input  logic           i_full,
    output logic           o_push,
    output stb_pkg::t_cmd  o_cmd
);
    import stb_pkg::*;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd.kind       = CMD_REJECT;
        o_cmd.rej_status = ST_NOT_FOUND;
        o_cmd.req_size   = i_req.req_size;
        o_cmd.block_addr = i_req.block_addr;
        priority if (i_req.opcode == OP_ALLOC) begin
            if (i_req.req_size == '0) begin
                o_cmd.rej_status = ST_NO_SLOT;
            end else begin
                o_cmd.kind = CMD_ALLOC;
            end
        end else if (i_req.opcode == OP_FREE || i_req.opcode == OP_QUERY) begin
            // null address never matches
            if (i_req.block_addr != '0) begin
                o_cmd.kind = (i_req.opcode == OP_FREE) ? CMD_FREE : CMD_QUERY;
            end
        end else begin
            o_cmd.kind = CMD_REJECT;
        end
    end

endmodule

[hdl/stb_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// stb_cmd_fifo
// Short command queue between the front and the engine.
// ----------------------------------------------------------------------------
module stb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stb_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output stb_pkg::t_cmd  o_cmd,
    output logic           o_empty
);
    import stb_pkg::*;

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wp;
    logic [CQ_PTR_W-1:0] r_rp;
    logic [CQ_CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CQ_CNT_W'(CQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + CQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + CQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CQ_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

[hdl/stb_engine.sv]
// ----------------------------------------------------------------------------
// stb_engine
// Walks the slot table one slot per cycle for allocate, free and query, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module stb_engine #(
    parameter int SLOTS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stb_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  logic [stb_pkg::ADDR_W-1:0]  i_pool_base,
    stb_rsp_if.source                   o_rsp
);
    import stb_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_eng_state         r_state, n_state;
    t_cmd               r_cmd;
    logic [IW-1:0]      r_idx;
    logic [ADDR_W-1:0]  r_cursor;
    logic [ADDR_W-1:0]  r_hit_off;

    t_slot_word         mem [SLOTS];
    t_slot_word         r_q;
    logic [SLOTS-1:0]   r_in_use;
    logic [SLOTS-1:0]   r_written;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [SIZE_W-1:0]  r_out_size;
    logic [INDEX_W-1:0] r_out_index;

    logic [SIZE_W-1:0]  cur_size;
    logic               cur_used;
    logic               is_last;
    logic [IW-1:0]      nxt_idx;
    logic               out_free;
    logic               start;
    logic               alloc_new;
    logic               alloc_reuse;
    logic               addr_hit;
    logic               scan_hit;
    logic               next_empty;

    logic [IW-1:0]      rd_addr;
    logic               mem_we;
    t_slot_word         wr_data;
    logic               use_set;
    logic               use_clr;
    logic               out_load;
    t_status            ld_status;
    logic [ADDR_W-1:0]  ld_addr;
    logic [SIZE_W-1:0]  ld_size;
    logic [INDEX_W-1:0] ld_index;

    // a slot never written reads as size zero
    assign cur_size    = r_written[r_idx] ? r_q.size : '0;
    assign cur_used    = r_in_use[r_idx];
    assign is_last     = r_idx == LAST_IDX;
    assign nxt_idx     = r_idx + IW'(1);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign start       = (r_state == ENG_IDLE) && i_cmd_valid && out_free;
    assign alloc_new   = cur_size == '0;
    assign alloc_reuse = !cur_used && (cur_size >= r_cmd.req_size);
    assign addr_hit    = cur_used && ((i_pool_base + r_q.offset) == r_cmd.block_addr);
    assign scan_hit    = (r_cmd.kind == CMD_ALLOC) ? (alloc_new || alloc_reuse) : addr_hit;
    assign next_empty  = !r_written[nxt_idx] || (r_q.size == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE: begin
                if (start && i_cmd.kind != CMD_REJECT) begin
                    n_state = ENG_SCAN;
                end
            end
            ENG_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_cmd.kind == CMD_FREE && !is_last) ? ENG_FREE_NEXT : ENG_IDLE;
                end else if (is_last) begin
                    n_state = ENG_IDLE;
                end
            end
            ENG_FREE_NEXT: n_state = ENG_IDLE;
            default:       n_state = ENG_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop      = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        wr_data.size   = '0;
        wr_data.offset = r_q.offset;
        use_set        = 1'b0;
        use_clr        = 1'b0;
        out_load       = 1'b0;
        ld_status      = ST_OK;
        ld_addr        = '0;
        ld_size        = '0;
        ld_index       = '0;
        unique case (r_state)
            ENG_IDLE: begin
                if (start) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_REJECT) begin
                        out_load  = 1'b1;
                        ld_status = i_cmd.rej_status;
                    end
                end
            end
            ENG_SCAN: begin
                // prefetch the next slot; a free needs it to decide on the size
                rd_addr = is_last ? r_idx : nxt_idx;
                if (scan_hit) begin
                    unique case (r_cmd.kind)
                        CMD_ALLOC: begin
                            mem_we         = 1'b1;
                            wr_data.size   = alloc_new ? r_cmd.req_size : cur_size;
                            wr_data.offset = r_cursor;
                            use_set        = 1'b1;
                            out_load       = 1'b1;
                            ld_addr        = i_pool_base + r_cursor;
                            ld_size        = alloc_new ? r_cmd.req_size : cur_size;
                            ld_index       = INDEX_W'(r_idx);
                        end
                        CMD_QUERY: begin
                            out_load = 1'b1;
                            ld_addr  = r_cmd.block_addr;
                            ld_size  = cur_size;
                            ld_index = INDEX_W'(r_idx);
                        end
                        CMD_FREE: begin
                            use_clr = 1'b1;
                            if (is_last) begin
                                mem_we   = 1'b1;
                                out_load = 1'b1;
                                ld_index = INDEX_W'(r_idx);
                            end
                        end
                        default: ;
                    endcase
                end else if (is_last) begin
                    out_load  = 1'b1;
                    ld_status = (r_cmd.kind == CMD_ALLOC) ? ST_NO_SLOT : ST_NOT_FOUND;
                end
            end
            ENG_FREE_NEXT: begin
                // forget the size when the following slot was never used
                mem_we         = next_empty;
                wr_data.offset = r_hit_off;
                out_load       = 1'b1;
                ld_index       = INDEX_W'(r_idx);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ENG_IDLE;
            r_in_use    <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (use_set) begin
                r_in_use[r_idx] <= 1'b1;
            end
            if (use_clr) begin
                r_in_use[r_idx] <= 1'b0;
            end
            if (mem_we) begin
                r_written[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd    <= i_cmd;
            r_idx    <= '0;
            r_cursor <= '0;
        end else if (r_state == ENG_SCAN && !scan_hit) begin
            r_cursor <= r_cursor + ADDR_W'(cur_size);
            if (!is_last) begin
                r_idx <= nxt_idx;
            end
        end
        if (r_state == ENG_SCAN) begin
            r_hit_off <= r_q.offset;
        end
        if (out_load) begin
            r_out_status <= ld_status;
            r_out_addr   <= ld_addr;
            r_out_size   <= ld_size;
            r_out_index  <= ld_index;
        end
    end

    // slot table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= wr_data;
        end
        r_q <= mem[rd_addr];
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_addr = r_out_addr;
    assign o_rsp.result_size = r_out_size;
    assign o_rsp.slot_index  = r_out_index;

endmodule

[verif/tb_slot_table_block_allocator.sv]
// ----------------------------------------------------------------------------
// tb_slot_table_block_allocator
// Self-checking bench for the slot table allocator. A scoreboard keeps its
// own copy of the slot table and the pool base and works out the response to
// every accepted request. A short directed run covers the corner cases, then
// random phases under several pool bases mix allocate, free, query and bad
// requests. Both sides of the handshake stall at random, except in one phase.
// ----------------------------------------------------------------------------
module tb_slot_table_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import stb_pkg::*;

    localparam int             SLOTS       = 32;
    localparam int             CYCLE_LIMIT = 600000;
    localparam int             HOLD_CYCLES = 400;
    localparam int             QUEUE_ROOM  = 3;
    localparam logic [OPCODE_W-1:0] OP_BAD = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [SIZE_W-1:0]   req_size;
        logic [ADDR_W-1:0]   block_addr;
    } t_request;

    typedef struct {
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic [INDEX_W-1:0]  index;
    } t_response;

    logic i_clk;
    logic i_rst_n;

    stb_cfg_if cfg_bus ();
    stb_req_if req_bus ();
    stb_rsp_if rsp_bus ();

    slot_table_block_allocator #(
        .SLOTS (SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // scoreboard copy of the allocator state
    logic [SIZE_W-1:0] tbl_size   [SLOTS];
    logic [ADDR_W-1:0] tbl_offset [SLOTS];
    logic              tbl_used   [SLOTS];
    logic [ADDR_W-1:0] pool_base;

    t_request  pending_req[$];
    t_response expected_rsp[$];
    t_request  req_in_flight;

    bit idle_on;
    bit hold_rsp;
    int send_gap;
    int drain_stall;
    int accepted_cnt;
    int checked_cnt;
    int mismatch_cnt;
    int cycle_cnt;

    int n_alloc_ok, n_reuse, n_table_full, n_zero_req;
    int n_free_ok, n_size_forgotten, n_query_ok, n_not_found, n_bad_op;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void predict_response(input t_request rq);
        t_response        r;
        int               hit;
        logic [ADDR_W-1:0] cursor;
        r.status = ST_NOT_FOUND;
        r.addr   = '0;
        r.size   = '0;
        r.index  = '0;
        hit      = -1;
        cursor   = '0;
        case (rq.opcode)
            OP_ALLOC: begin
                r.status = ST_NO_SLOT;
                if (rq.req_size == 0) begin
                    n_zero_req++;
                end else begin
                    for (int i = 0; i < SLOTS && hit < 0; i++) begin
                        if (tbl_size[i] == 0 || (!tbl_used[i] && tbl_size[i] >= rq.req_size))
                            hit = i;
                        else
                            cursor += ADDR_W'(tbl_size[i]);
                    end
                    if (hit < 0) begin
                        n_table_full++;
                    end else begin
                        if (tbl_size[hit] == 0)
                            tbl_size[hit] = rq.req_size;
                        else
                            n_reuse++;
                        tbl_offset[hit] = cursor;
                        tbl_used[hit]   = 1'b1;
                        r.status = ST_OK;
                        r.addr   = pool_base + cursor;
                        r.size   = tbl_size[hit];
                        r.index  = INDEX_W'(hit);
                        n_alloc_ok++;
                    end
                end
            end
            OP_FREE, OP_QUERY: begin
                if (rq.block_addr != 0) begin
                    for (int i = 0; i < SLOTS && hit < 0; i++) begin
                        if (tbl_used[i] && pool_base + tbl_offset[i] == rq.block_addr)
                            hit = i;
                    end
                end
                if (hit < 0) begin
                    n_not_found++;
                end else begin
                    r.status = ST_OK;
                    r.index  = INDEX_W'(hit);
                    if (rq.opcode == OP_FREE) begin
                        tbl_used[hit] = 1'b0;
                        // forget the size when nothing was ever laid out behind it
                        if (hit == SLOTS - 1 || tbl_size[hit + 1] == 0) begin
                            tbl_size[hit] = '0;
                            n_size_forgotten++;
                        end
                        n_free_ok++;
                    end else begin
                        r.addr = rq.block_addr;
                        r.size = tbl_size[hit];
                        n_query_ok++;
                    end
                end
            end
            default: n_bad_op++;
        endcase
        expected_rsp.push_back(r);
    endfunction

    function automatic t_request make_request(input int alloc_pct, input int free_pct);
        t_request rq;
        int       roll;
        int       live[$];
        rq.opcode     = OP_QUERY;
        rq.req_size   = SIZE_W'($urandom);
        rq.block_addr = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            rq.opcode = OP_ALLOC;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                rq.req_size = '0;
            else if (roll < 8)
                rq.req_size = '1;
            else if (roll >= 18)
                rq.req_size = SIZE_W'($urandom_range(1, 48));
        end else if (roll < 96) begin
            if (roll < alloc_pct + free_pct)
                rq.opcode = OP_FREE;
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i])
                    live.push_back(i);
            roll = $urandom_range(0, 99);
            if (live.size() > 0 && roll < 80) begin
                rq.block_addr = pool_base + tbl_offset[live[$urandom_range(0, live.size() - 1)]];
                // near miss: flip one address bit
                if (roll >= 70)
                    rq.block_addr ^= ADDR_W'(1) << $urandom_range(0, ADDR_W - 1);
            end else if (roll < 90) begin
                rq.block_addr = '0;
            end
        end else begin
            rq.opcode = OP_BAD;
        end
        return rq;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predict_response(req_in_flight);
                accepted_cnt++;
                send_gap = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap == 0 && pending_req.size() > 0) begin
                    req_in_flight = pending_req.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.opcode     <= req_in_flight.opcode;
                    req_bus.req_size   <= req_in_flight.req_size;
                    req_bus.block_addr <= req_in_flight.block_addr;
                end else begin
                    if (send_gap != 0)
                        send_gap--;
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            drain_stall = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                checked_cnt++;
                if (expected_rsp.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] unexpected response: st=%0d addr=%h size=%h idx=%0d",
                                 $realtime, rsp_bus.status, rsp_bus.result_addr,
                                 rsp_bus.result_size, rsp_bus.slot_index);
                end else begin
                    t_response exp_rsp;
                    exp_rsp = expected_rsp.pop_front();
                    if (rsp_bus.status !== exp_rsp.status ||
                        rsp_bus.result_addr !== exp_rsp.addr ||
                        rsp_bus.result_size !== exp_rsp.size ||
                        rsp_bus.slot_index !== exp_rsp.index) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("[%0t] response %0d mismatch: expected st=%0d addr=%h size=%h idx=%0d",
                                     $realtime, checked_cnt, exp_rsp.status, exp_rsp.addr,
                                     exp_rsp.size, exp_rsp.index);
                            $display("    got st=%0d addr=%h size=%h idx=%0d",
                                     rsp_bus.status, rsp_bus.result_addr,
                                     rsp_bus.result_size, rsp_bus.slot_index);
                        end
                    end
                end
                drain_stall = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_rsp || drain_stall != 0) begin
                if (!hold_rsp)
                    drain_stall--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // long response hold-off so the command queue fills and the request side stalls
    initial begin
        hold_rsp = 1'b0;
        wait (accepted_cnt >= 760);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses still due",
                     cycle_cnt, expected_rsp.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_for_room();
        do @(negedge i_clk); while (pending_req.size() >= QUEUE_ROOM);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_req.size() != 0 || req_bus.valid || expected_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send(input logic [OPCODE_W-1:0] op, input logic [SIZE_W-1:0] sz,
                        input logic [ADDR_W-1:0] ad);
        t_request rq;
        rq.opcode     = op;
        rq.req_size   = sz;
        rq.block_addr = ad;
        wait_for_room();
        pending_req.push_back(rq);
    endtask

    task automatic write_pool_base(input logic [ADDR_W-1:0] base);
        wait_drained();
        repeat (SLOTS + 4) @(posedge i_clk);
        cfg_bus.data  <= base;
        cfg_bus.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        pool_base = base;
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] base, input int count,
                             input int alloc_pct, input int free_pct, input bit idling);
        write_pool_base(base);
        @(negedge i_clk);
        idle_on = idling;
        for (int n = 0; n < count; n++) begin
            // hold the sender once per phase until everything has drained
            if (n == count / 2)
                wait_drained();
            wait_for_room();
            pending_req.push_back(make_request(alloc_pct, free_pct));
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.opcode     = '0;
        req_bus.req_size   = '0;
        req_bus.block_addr = '0;
        rsp_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.data       = '0;
        idle_on            = 1'b1;
        pool_base          = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_size[i]   = '0;
            tbl_offset[i] = '0;
            tbl_used[i]   = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases, pool base at its reset value
        send(OP_ALLOC, 24'd0, 32'hFFFF_FFFF);
        send(OP_FREE,  24'hFF_FFFF, 32'd0);
        send(OP_QUERY, 24'd0, 32'd0);
        send(OP_BAD,   24'hFF_FFFF, 32'hFFFF_FFFF);
        send(OP_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send(OP_ALLOC, 24'd1, 32'd0);
        send(OP_ALLOC, 24'd16, 32'd0);
        send(OP_QUERY, 24'd0, 32'd0);
        send(OP_QUERY, 24'd0, 32'h00FF_FFFF);
        send(OP_FREE,  24'd0, 32'h00FF_FFFF);
        send(OP_QUERY, 24'd0, 32'h00FF_FFFF);
        send(OP_ALLOC, 24'd1, 32'd0);
        send(OP_FREE,  24'd0, 32'h1234_5678);
        send(OP_FREE,  24'd0, 32'h0100_0000);
        send(OP_ALLOC, 24'd8, 32'd0);
        // addresses wrap past the top of the address space
        write_pool_base(32'hFFFF_FFF8);
        send(OP_ALLOC, 24'd4, 32'd0);
        send(OP_QUERY, 24'd0, 32'h00FF_FFF7);
        send(OP_FREE,  24'd0, 32'hFFFF_FFF8);
        send(OP_ALLOC, 24'd2, 32'd0);
        send(OP_FREE,  24'd0, 32'h00FF_FFF8);

        run_phase($urandom,     350, 45, 30, 1'b1);
        run_phase(32'hFFFF_FFFF, 350, 70, 15, 1'b0);
        run_phase(32'h0000_0000, 350, 40, 35, 1'b1);
        run_phase(32'hFFFF_0000, 350, 35, 45, 1'b1);

        wait_drained();
        repeat (2 * SLOTS + 8) @(posedge i_clk);

        $display("%0d requests checked over 6 pool bases: %0d allocs (%0d reused), %0d full,",
                 checked_cnt, n_alloc_ok, n_reuse, n_table_full);
        $display("%0d zero-size, %0d frees (%0d size dropped), %0d queries, %0d misses, %0d bad ops",
                 n_zero_req, n_free_ok, n_size_forgotten, n_query_ok, n_not_found, n_bad_op);
        if (mismatch_cnt == 0 && expected_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatch_cnt, expected_rsp.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
